>>> rtl/core/ctin_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctin_pkg: shared types and constants for column type inference
// Command codes, parse phases, result type codes and the classified token
// that travels from the front stage through the queue to the back stage.
// ----------------------------------------------------------------------------
package ctin_pkg;

  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,
    CMD_EOV  = 2'd1,
    CMD_EOC  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_SIGN  = 3'd1,
    PH_WHOLE = 3'd2,
    PH_POINT = 3'd3,
    PH_FRAC  = 3'd4,
    PH_FAIL  = 3'd5
  } phase_t;

  localparam logic [2:0] TYPE_TEXT    = 3'd0;
  localparam logic [2:0] TYPE_INT32   = 3'd1;
  localparam logic [2:0] TYPE_INT64   = 3'd2;
  localparam logic [2:0] TYPE_DECIMAL = 3'd3;
  localparam logic [2:0] TYPE_STAMP   = 3'd4;
  localparam logic [2:0] TYPE_DATE    = 3'd5;

  localparam logic [4:0] POS_MAX       = 5'd20;
  localparam logic [4:0] WHOLE_MAX     = 5'd19;
  localparam logic [4:0] INT32_DIGITS  = 5'd9;
  localparam logic [4:0] INT64_DIGITS  = 5'd18;
  localparam logic [5:0] SCALE_MAX     = 6'd38;
  localparam logic [4:0] DATE_LEN      = 5'd10;
  localparam logic [4:0] STAMP_MIN_LEN = 5'd19;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    cmd_t cmd;
    logic is_digit;
    logic is_zero;
    logic is_sign;
    logic is_dot;
    logic is_dash;
    logic is_colon;
    logic is_tsep;
  } token_t;

endpackage

>>> rtl/core/ctin_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctin_front: input stage
// Accepts command and byte transfers, classifies the byte into character
// classes and holds the token until the queue takes it.
// ----------------------------------------------------------------------------
module ctin_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // char_byte[7:0]
  input  logic [1:0]          in_tuser,   // command[1:0]
  output logic                tok_valid,
  input  logic                tok_ready,
  output ctin_pkg::token_t    tok
);

  logic              valid_r;
  logic              valid_nxt;
  ctin_pkg::token_t  tok_r;
  ctin_pkg::token_t  tok_nxt;
  logic              take;

  assign in_tready = !valid_r || tok_ready;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    tok_nxt.cmd      = ctin_pkg::cmd_t'(in_tuser);
    tok_nxt.is_digit = (in_tdata >= 8'h30) && (in_tdata <= 8'h39);
    tok_nxt.is_zero  = (in_tdata == 8'h30);
    tok_nxt.is_sign  = (in_tdata == 8'h2b) || (in_tdata == 8'h2d);
    tok_nxt.is_dot   = (in_tdata == 8'h2e);
    tok_nxt.is_dash  = (in_tdata == 8'h2d);
    tok_nxt.is_colon = (in_tdata == 8'h3a);
    tok_nxt.is_tsep  = (in_tdata == 8'h54) || (in_tdata == 8'h20);
    valid_nxt = valid_r && !tok_ready;
    if (take && (tok_nxt.cmd != ctin_pkg::CMD_NONE)) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_valid = valid_r;
  assign tok       = tok_r;

endmodule

>>> rtl/core/ctin_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctin_fifo: token queue
// A short first-in first-out queue that lets the front and back stages
// stall independently of each other.
// ----------------------------------------------------------------------------
module ctin_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  ctin_pkg::token_t    wr_tok,
  output logic                rd_valid,
  input  logic                rd_ready,
  output ctin_pkg::token_t    rd_tok
);

  ctin_pkg::token_t             mem_r [ctin_pkg::QDEPTH];
  logic [ctin_pkg::QAW-1:0]     wr_ptr_r;
  logic [ctin_pkg::QAW-1:0]     wr_ptr_nxt;
  logic [ctin_pkg::QAW-1:0]     rd_ptr_r;
  logic [ctin_pkg::QAW-1:0]     rd_ptr_nxt;
  logic [ctin_pkg::QAW:0]       count_r;
  logic [ctin_pkg::QAW:0]       count_nxt;
  logic                         push;
  logic                         pop;

  assign wr_ready = (count_r != (ctin_pkg::QAW+1)'(ctin_pkg::QDEPTH));
  assign rd_valid = (count_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_tok   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_tok;
    end
  end

  property p_count_bounded;
    @(posedge clk) disable iff (!rst_n)
      count_r <= (ctin_pkg::QAW+1)'(ctin_pkg::QDEPTH);
  endproperty
  a_count_bounded: assert property (p_count_bounded) else $error("queue overfilled");

  property p_count_tracks;
    @(posedge clk) disable iff (!rst_n)
      (push && !pop) |=> (count_r == $past(count_r) + 1'b1);
  endproperty
  a_count_tracks: assert property (p_count_tracks) else $error("queue count lost a push");

endmodule

>>> rtl/core/ctin_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctin_back: value parser and column accumulator
// Applies each token to the per-value parse state and the per-column flags,
// and at end of column places the inferred type in the output register.
// ----------------------------------------------------------------------------
module ctin_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tok_valid,
  output logic                tok_ready,
  input  ctin_pkg::token_t    tok,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata   // column_type[2:0], decimal_scale[8:3]
);

  logic [4:0]         char_position_r, char_position_nxt;
  ctin_pkg::phase_t   number_phase_r, number_phase_nxt;
  logic [4:0]         whole_count_r, whole_count_nxt;
  logic               first_zero_r, first_zero_nxt;
  logic [5:0]         frac_count_r, frac_count_nxt;
  logic               date_ok_r, date_ok_nxt;
  logic               stamp_ok_r, stamp_ok_nxt;
  logic               saw_any_r, saw_any_nxt;
  logic               all_int32_r, all_int32_nxt;
  logic               all_int64_r, all_int64_nxt;
  logic               all_dec_r, all_dec_nxt;
  logic               every_date_r, every_date_nxt;
  logic               all_stamp_r, all_stamp_nxt;
  logic [5:0]         peak_scale_r, peak_scale_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_type_r, out_type_nxt;
  logic [5:0]         out_scale_r, out_scale_nxt;

  logic               pop;
  logic               nonempty;
  logic               lead_zero;
  logic               is_int;
  logic               is_dec;
  logic               c_saw;
  logic               c_int32;
  logic               c_int64;
  logic               c_dec;
  logic               c_date;
  logic               c_stamp;
  logic [5:0]         c_scale;
  logic               pos_ok;

  assign tok_ready = (tok.cmd != ctin_pkg::CMD_EOC) || !out_valid_r || out_tready;
  assign pop       = tok_valid && tok_ready;

  always_comb begin
    nonempty  = (char_position_r != '0);
    lead_zero = (whole_count_r > 5'd1) && first_zero_r;
    is_int    = (number_phase_r == ctin_pkg::PH_WHOLE) && !lead_zero;
    is_dec    = (number_phase_r == ctin_pkg::PH_FRAC) && !lead_zero;
    c_saw     = saw_any_r || nonempty;
    c_int32   = all_int32_r;
    c_int64   = all_int64_r;
    c_dec     = all_dec_r;
    c_date    = every_date_r;
    c_stamp   = all_stamp_r;
    c_scale   = peak_scale_r;
    if (nonempty) begin
      c_int32 = all_int32_r && is_int && (whole_count_r <= ctin_pkg::INT32_DIGITS);
      c_int64 = all_int64_r && is_int && (whole_count_r <= ctin_pkg::INT64_DIGITS);
      c_dec   = all_dec_r && (is_int || is_dec);
      c_date  = every_date_r && date_ok_r && (char_position_r == ctin_pkg::DATE_LEN);
      c_stamp = all_stamp_r && stamp_ok_r && (char_position_r >= ctin_pkg::STAMP_MIN_LEN);
      if (is_dec && (frac_count_r > peak_scale_r)) begin
        c_scale = frac_count_r;
      end
    end

    if ((char_position_r == 5'd4) || (char_position_r == 5'd7)) begin
      pos_ok = tok.is_dash;
    end else if ((char_position_r == 5'd13) || (char_position_r == 5'd16)) begin
      pos_ok = tok.is_colon;
    end else if (char_position_r == 5'd10) begin
      pos_ok = tok.is_tsep;
    end else begin
      pos_ok = tok.is_digit;
    end

    char_position_nxt = char_position_r;
    number_phase_nxt  = number_phase_r;
    whole_count_nxt   = whole_count_r;
    first_zero_nxt    = first_zero_r;
    frac_count_nxt    = frac_count_r;
    date_ok_nxt       = date_ok_r;
    stamp_ok_nxt      = stamp_ok_r;
    saw_any_nxt       = saw_any_r;
    all_int32_nxt     = all_int32_r;
    all_int64_nxt     = all_int64_r;
    all_dec_nxt       = all_dec_r;
    every_date_nxt    = every_date_r;
    all_stamp_nxt     = all_stamp_r;
    peak_scale_nxt    = peak_scale_r;
    out_valid_nxt     = out_valid_r && !out_tready;
    out_type_nxt      = out_type_r;
    out_scale_nxt     = out_scale_r;

    if (pop) begin
      case (tok.cmd)
        ctin_pkg::CMD_CHAR: begin
          case (number_phase_r)
            ctin_pkg::PH_START, ctin_pkg::PH_SIGN: begin
              if ((number_phase_r == ctin_pkg::PH_START) && tok.is_sign) begin
                number_phase_nxt = ctin_pkg::PH_SIGN;
              end else if (tok.is_digit) begin
                number_phase_nxt = ctin_pkg::PH_WHOLE;
                whole_count_nxt  = 5'd1;
                first_zero_nxt   = tok.is_zero;
              end else begin
                number_phase_nxt = ctin_pkg::PH_FAIL;
              end
            end
            ctin_pkg::PH_WHOLE: begin
              if (tok.is_digit) begin
                if (whole_count_r < ctin_pkg::WHOLE_MAX) begin
                  whole_count_nxt = whole_count_r + 5'd1;
                end
              end else if (tok.is_dot) begin
                number_phase_nxt = ctin_pkg::PH_POINT;
              end else begin
                number_phase_nxt = ctin_pkg::PH_FAIL;
              end
            end
            ctin_pkg::PH_POINT, ctin_pkg::PH_FRAC: begin
              if (tok.is_digit) begin
                number_phase_nxt = ctin_pkg::PH_FRAC;
                if (frac_count_r < ctin_pkg::SCALE_MAX) begin
                  frac_count_nxt = frac_count_r + 6'd1;
                end
              end else begin
                number_phase_nxt = ctin_pkg::PH_FAIL;
              end
            end
            default: begin
              number_phase_nxt = ctin_pkg::PH_FAIL;
            end
          endcase
          if (char_position_r < ctin_pkg::DATE_LEN) begin
            if (!pos_ok) begin
              date_ok_nxt  = 1'b0;
              stamp_ok_nxt = 1'b0;
            end
          end else begin
            date_ok_nxt = 1'b0;
            if ((char_position_r < ctin_pkg::STAMP_MIN_LEN) && !pos_ok) begin
              stamp_ok_nxt = 1'b0;
            end
          end
          if (char_position_r < ctin_pkg::POS_MAX) begin
            char_position_nxt = char_position_r + 5'd1;
          end
        end
        ctin_pkg::CMD_EOV, ctin_pkg::CMD_EOC: begin
          char_position_nxt = '0;
          number_phase_nxt  = ctin_pkg::PH_START;
          whole_count_nxt   = '0;
          first_zero_nxt    = 1'b0;
          frac_count_nxt    = '0;
          date_ok_nxt       = 1'b1;
          stamp_ok_nxt      = 1'b1;
          saw_any_nxt       = c_saw;
          all_int32_nxt     = c_int32;
          all_int64_nxt     = c_int64;
          all_dec_nxt       = c_dec;
          every_date_nxt    = c_date;
          all_stamp_nxt     = c_stamp;
          peak_scale_nxt    = c_scale;
          if (tok.cmd == ctin_pkg::CMD_EOC) begin
            out_valid_nxt = 1'b1;
            out_scale_nxt = '0;
            if (!c_saw) begin
              out_type_nxt = ctin_pkg::TYPE_TEXT;
            end else if (c_int32) begin
              out_type_nxt = ctin_pkg::TYPE_INT32;
            end else if (c_int64) begin
              out_type_nxt = ctin_pkg::TYPE_INT64;
            end else if (c_dec) begin
              out_type_nxt  = ctin_pkg::TYPE_DECIMAL;
              out_scale_nxt = c_scale;
            end else if (c_stamp) begin
              out_type_nxt = ctin_pkg::TYPE_STAMP;
            end else if (c_date) begin
              out_type_nxt = ctin_pkg::TYPE_DATE;
            end else begin
              out_type_nxt = ctin_pkg::TYPE_TEXT;
            end
            saw_any_nxt    = 1'b0;
            all_int32_nxt  = 1'b1;
            all_int64_nxt  = 1'b1;
            all_dec_nxt    = 1'b1;
            every_date_nxt = 1'b1;
            all_stamp_nxt  = 1'b1;
            peak_scale_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_position_r <= '0;
      number_phase_r  <= ctin_pkg::PH_START;
      whole_count_r   <= '0;
      first_zero_r    <= 1'b0;
      frac_count_r    <= '0;
      date_ok_r       <= 1'b1;
      stamp_ok_r      <= 1'b1;
      saw_any_r       <= 1'b0;
      all_int32_r     <= 1'b1;
      all_int64_r     <= 1'b1;
      all_dec_r       <= 1'b1;
      every_date_r    <= 1'b1;
      all_stamp_r     <= 1'b1;
      peak_scale_r    <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      char_position_r <= char_position_nxt;
      number_phase_r  <= number_phase_nxt;
      whole_count_r   <= whole_count_nxt;
      first_zero_r    <= first_zero_nxt;
      frac_count_r    <= frac_count_nxt;
      date_ok_r       <= date_ok_nxt;
      stamp_ok_r      <= stamp_ok_nxt;
      saw_any_r       <= saw_any_nxt;
      all_int32_r     <= all_int32_nxt;
      all_int64_r     <= all_int64_nxt;
      all_dec_r       <= all_dec_nxt;
      every_date_r    <= every_date_nxt;
      all_stamp_r     <= all_stamp_nxt;
      peak_scale_r    <= peak_scale_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_type_r  <= out_type_nxt;
    out_scale_r <= out_scale_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_scale_r, out_type_r};

  property p_eoc_clears_column;
    @(posedge clk) disable iff (!rst_n)
      (pop && (tok.cmd == ctin_pkg::CMD_EOC)) |=>
        (!saw_any_r && (peak_scale_r == '0) && (char_position_r == '0));
  endproperty
  a_eoc_clears_column: assert property (p_eoc_clears_column)
    else $error("column state not cleared after end of column");

  property p_scale_only_decimal;
    @(posedge clk) disable iff (!rst_n)
      (out_valid_r && (out_type_r != ctin_pkg::TYPE_DECIMAL)) |-> (out_scale_r == '0);
  endproperty
  a_scale_only_decimal: assert property (p_scale_only_decimal)
    else $error("nonzero scale on a non-decimal result");

  property p_counters_saturate;
    @(posedge clk) disable iff (!rst_n)
      (char_position_r <= ctin_pkg::POS_MAX) && (frac_count_r <= ctin_pkg::SCALE_MAX) &&
      (whole_count_r <= ctin_pkg::WHOLE_MAX) && (peak_scale_r <= ctin_pkg::SCALE_MAX);
  endproperty
  a_counters_saturate: assert property (p_counters_saturate)
    else $error("counter passed its saturation limit");

endmodule

>>> rtl/core/column_type_inference_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_type_inference_top: column type inference
// Classifies the bytes of a column's sample values in a front stage, queues
// the tokens, and infers the narrowest fitting type in a back stage.
// ----------------------------------------------------------------------------
// Throughput: one transfer per cycle on the input, for bytes and commands, while the
// queue has room; an end-of-column token waits in the queue while the previous result is not taken.
// Result path: out_tvalid rises once the end-of-column token has passed the front
// register, the queue and the output register, in that order.
// Reset: synchronous, active low; clears all value and column state and
// empties the queue and the output register.
// ----------------------------------------------------------------------------
module column_type_inference_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_byte[7:0]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // column_type[2:0], decimal_scale[8:3], zero above
);

  logic              f_valid;
  logic              f_ready;
  ctin_pkg::token_t  f_tok;
  logic              q_valid;
  logic              q_ready;
  ctin_pkg::token_t  q_tok;

  ctin_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .tok_valid (f_valid),
    .tok_ready (f_ready),
    .tok       (f_tok)
  );

  ctin_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_tok   (f_tok),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_tok   (q_tok)
  );

  ctin_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_valid  (q_valid),
    .tok_ready  (q_ready),
    .tok        (q_tok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
